// ----- sv/sltm_pkg.sv -----
// Shared types and constants for the serial line template matcher.
// Used by sltm_cfg_regs, sltm_line_scan and serial_line_template_matcher_unit.
package sltm_pkg;

  // Character codes
  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_LF   = 8'd10;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Template holds up to eight characters; the number after it up to three digits
  localparam int unsigned TMPL_MAX   = 8;
  localparam int unsigned NUM_DIGITS = 3;

  localparam int unsigned TMPL_BITS  = 8 * TMPL_MAX;
  localparam int unsigned TLEN_W     = 4;
  localparam int unsigned ACC_W      = 10;
  localparam int unsigned LEN_OUT_W  = 7;
  localparam int unsigned NUM_OUT_W  = 11;
  localparam int unsigned OUT_DATA_W = 24;

  // Configuration register indexes
  localparam logic REG_TEMPLATE_TEXT   = 1'b0;
  localparam logic REG_TEMPLATE_LENGTH = 1'b1;

  // Active template, length already clamped to TMPL_MAX
  typedef struct packed {
    logic [TMPL_BITS-1:0] text;
    logic [TLEN_W-1:0]    len;
  } tmpl_cfg_t;

  // One finished line
  typedef struct packed {
    logic signed [NUM_OUT_W-1:0] trailing_number;
    logic                        equals_template;
    logic                        starts_with_template;
    logic                        overflowed;
    logic [LEN_OUT_W-1:0]        line_length;
  } line_result_t;

endpackage

// ----- sv/sltm_cfg_regs.sv -----
// Configuration registers of the serial line template matcher.
// Depends on sltm_pkg for register indexes and the template struct.
module sltm_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic                            wr_index,
  input  logic [sltm_pkg::TMPL_BITS-1:0]  wr_data,
  output sltm_pkg::tmpl_cfg_t             tmpl
);

  logic [sltm_pkg::TMPL_BITS-1:0] text_r;
  logic [sltm_pkg::TLEN_W-1:0]    len_r;

  // Store register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_r <= '0;
      len_r  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        sltm_pkg::REG_TEMPLATE_TEXT:   text_r <= wr_data;
        sltm_pkg::REG_TEMPLATE_LENGTH: len_r  <= wr_data[sltm_pkg::TLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length to the template width
  always_comb begin
    tmpl.text = text_r;
    if (len_r > sltm_pkg::TLEN_W'(sltm_pkg::TMPL_MAX))
      tmpl.len = sltm_pkg::TLEN_W'(sltm_pkg::TMPL_MAX);
    else
      tmpl.len = len_r;
  end

endmodule

// ----- sv/sltm_line_scan.sv -----
// Input register and per-line scan state of the template matcher.
// Depends on sltm_pkg for character codes and the result struct.
module sltm_line_scan #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 advance,
  input  sltm_pkg::tmpl_cfg_t  tmpl,
  output logic                 res_valid,
  output sltm_pkg::line_result_t res
);

  localparam int unsigned CW = $clog2(BUF_DEPTH + 1);

  logic                          byte_valid_r;
  logic [7:0]                    byte_r;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          prefix_ok_r, prefix_ok_nxt;
  logic [sltm_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic                          digits_ok_r, digits_ok_nxt;

  logic                          fire;
  logic                          is_eol;
  logic                          is_digit;
  logic [CW-1:0]                 tl;
  logic [CW-1:0]                 tail_pos;
  logic [7:0]                    tmpl_char;
  logic [sltm_pkg::ACC_W-1:0]    digit_val;

  assign in_ready = !byte_valid_r || advance;
  assign fire     = byte_valid_r && advance;

  // Hold the received byte until the scan stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else if (in_ready) begin
      byte_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
  end

  // Decode the current byte
  assign is_eol    = (byte_r == sltm_pkg::CHAR_CR) || (byte_r == sltm_pkg::CHAR_LF);
  assign is_digit  = (byte_r >= sltm_pkg::CHAR_ZERO) && (byte_r <= sltm_pkg::CHAR_NINE);
  assign tl        = CW'(tmpl.len);
  assign tail_pos  = cnt_r - tl;
  assign tmpl_char = tmpl.text[8*cnt_r[2:0] +: 8];
  assign digit_val = sltm_pkg::ACC_W'(byte_r - sltm_pkg::CHAR_ZERO);

  // Advance the line state by one character, or only flag overflow once the buffer is full; clear it at a line end
  always_comb begin
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    prefix_ok_nxt = prefix_ok_r;
    acc_nxt       = acc_r;
    digits_ok_nxt = digits_ok_r;
    if (is_eol) begin
      cnt_nxt       = '0;
      ovf_nxt       = 1'b0;
      prefix_ok_nxt = 1'b1;
      acc_nxt       = '0;
      digits_ok_nxt = 1'b1;
    end else if (cnt_r >= CW'(BUF_DEPTH)) begin
      ovf_nxt = 1'b1;
    end else begin
      if (cnt_r < tl) begin
        if (tmpl_char != byte_r) prefix_ok_nxt = 1'b0;
      end else if (!is_digit) begin
        digits_ok_nxt = 1'b0;
      end else if (tail_pos < CW'(sltm_pkg::NUM_DIGITS)) begin
        acc_nxt = sltm_pkg::ACC_W'(acc_r * sltm_pkg::ACC_W'(10)) + digit_val;
      end
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      prefix_ok_r <= 1'b1;
      acc_r       <= '0;
      digits_ok_r <= 1'b1;
    end else if (fire) begin
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      prefix_ok_r <= prefix_ok_nxt;
      acc_r       <= acc_nxt;
      digits_ok_r <= digits_ok_nxt;
    end
  end

  // Build the line result from the state before the line end
  assign res_valid = fire && is_eol;

  always_comb begin
    res.line_length          = sltm_pkg::LEN_OUT_W'(cnt_r);
    res.overflowed           = ovf_r;
    res.starts_with_template = prefix_ok_r && (cnt_r >= tl);
    res.equals_template      = prefix_ok_r && (cnt_r == tl);
    if (!digits_ok_r || (cnt_r > tl + CW'(sltm_pkg::NUM_DIGITS)))
      res.trailing_number = '1;
    else if (cnt_r <= tl)
      res.trailing_number = '0;
    else
      res.trailing_number = sltm_pkg::NUM_OUT_W'(acc_r);
  end

  // Checks on the scan state
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(BUF_DEPTH))
    else $error("character count beyond buffer depth");

  a_clear_after_eol: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (cnt_r == '0) && !ovf_r && prefix_ok_r && digits_ok_r && (acc_r == '0))
    else $error("line state not cleared after line end");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == CW'(BUF_DEPTH)))
    else $error("overflow flagged before buffer filled");

  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r < sltm_pkg::ACC_W'(1000))
    else $error("number accumulator beyond three digits");

endmodule

// ----- sv/serial_line_template_matcher_unit.sv -----
// Serial line template matcher, top level.
// A line-end byte is first held in the input register; when the scan advances, its line's
// result is built from the scan state and registered in the output register.
// Throughput: one byte per cycle; the scan register advances whenever the output
// register is empty or being taken. rst_n is synchronous, active low, and clears the
// line state, the template registers and both valid flags.
module serial_line_template_matcher_unit #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] rx_byte
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [6:0] line_length, [7] overflowed, [8] starts_with_template,
  // [9] equals_template, [20:10] trailing_number, [23:21] zero
  output logic [sltm_pkg::OUT_DATA_W-1:0]     out_tdata,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [sltm_pkg::TMPL_BITS-1:0]      cfg_data
);

  sltm_pkg::tmpl_cfg_t    tmpl;
  sltm_pkg::line_result_t scan_res;
  sltm_pkg::line_result_t res_r;
  logic                   scan_res_valid;
  logic                   out_valid_r;
  logic                   advance;

  assign cfg_ready = 1'b1;

  sltm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .tmpl     (tmpl)
  );

  // Advance when the output register is free or its result transfers now
  assign advance = !out_valid_r || out_tready;

  sltm_line_scan #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .advance   (advance),
    .tmpl      (tmpl),
    .res_valid (scan_res_valid),
    .res       (scan_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= scan_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && scan_res_valid) begin
      res_r <= scan_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(sltm_pkg::OUT_DATA_W - $bits(res_r)){1'b0}}, res_r};

endmodule

// ----- tb/sv/serial_line_template_matcher_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for serial_line_template_matcher_unit: streams bytes in and
// checks every line result against an in-order prediction. Needs sltm_pkg and the unit RTL.
module serial_line_template_matcher_unit_tb;

  localparam int unsigned BUF_DEPTH   = 64;
  localparam int unsigned MAX_REPORTS = 10;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [7:0]                      in_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [sltm_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic                            cfg_index;
  logic [sltm_pkg::TMPL_BITS-1:0]  cfg_data;

  // Predicted line state and template registers
  logic [sltm_pkg::TMPL_BITS-1:0]  tmpl_text;
  logic [sltm_pkg::TLEN_W-1:0]     tmpl_len;
  int unsigned                     line_chars;
  bit                              line_dropped;
  bit                              prefix_match;
  int unsigned                     digit_value;
  bit                              digits_only;

  sltm_pkg::line_result_t          expected_lines[$];
  int unsigned                     mismatch_count;
  int unsigned                     bytes_sent;
  bit                              steady;

  serial_line_template_matcher_unit #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned active_tmpl_len();
    return (tmpl_len > sltm_pkg::TMPL_MAX) ? sltm_pkg::TMPL_MAX : tmpl_len;
  endfunction

  function automatic void clear_line_state();
    line_chars   = 0;
    line_dropped = 1'b0;
    prefix_match = 1'b1;
    digit_value  = 0;
    digits_only  = 1'b1;
  endfunction

  // Advance the predicted line by one byte; return 1 with the result on a line end
  function automatic bit scan_byte(input logic [7:0] c,
                                   output sltm_pkg::line_result_t res);
    int unsigned tl;
    tl  = active_tmpl_len();
    res = '0;
    if (c == sltm_pkg::CHAR_CR || c == sltm_pkg::CHAR_LF) begin
      res.line_length          = line_chars[sltm_pkg::LEN_OUT_W-1:0];
      res.overflowed           = line_dropped;
      res.starts_with_template = prefix_match && (line_chars >= tl);
      res.equals_template      = prefix_match && (line_chars == tl);
      if (line_chars > tl + sltm_pkg::NUM_DIGITS || !digits_only)
        res.trailing_number = '1;
      else if (line_chars <= tl)
        res.trailing_number = '0;
      else
        res.trailing_number = digit_value[sltm_pkg::NUM_OUT_W-1:0];
      clear_line_state();
      return 1'b1;
    end
    // Drop bytes past the buffer, only remember that they came
    if (line_chars >= BUF_DEPTH) begin
      line_dropped = 1'b1;
      return 1'b0;
    end
    if (line_chars < tl) begin
      if (tmpl_text[8*line_chars +: 8] != c)
        prefix_match = 1'b0;
    end else if (c < sltm_pkg::CHAR_ZERO || c > sltm_pkg::CHAR_NINE) begin
      digits_only = 1'b0;
    end else if (line_chars - tl < sltm_pkg::NUM_DIGITS) begin
      digit_value = digit_value * 10 + (c - sltm_pkg::CHAR_ZERO);
    end
    line_chars++;
    return 1'b0;
  endfunction

  function automatic logic [sltm_pkg::TMPL_BITS-1:0] pack_text(input string s);
    logic [sltm_pkg::TMPL_BITS-1:0] t;
    t = '0;
    for (int i = 0; i < s.len() && i < sltm_pkg::TMPL_MAX; i++)
      t[8*i +: 8] = s[i];
    return t;
  endfunction

  // Offer one byte, with random gaps, and predict once the transfer happens
  task automatic send_byte(input logic [7:0] b);
    sltm_pkg::line_result_t res;
    while (!steady && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (scan_byte(b, res))
      expected_lines.push_back(res);
    bytes_sent++;
  endtask

  task automatic send_line(input string s, input logic [7:0] term);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i]);
    send_byte(term);
  endtask

  // Hold the input idle until every result is in and the scan has settled
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both template registers back to back; call only while idle
  task automatic load_template(input logic [sltm_pkg::TMPL_BITS-1:0] text,
                               input logic [sltm_pkg::TLEN_W-1:0] len);
    logic [sltm_pkg::TMPL_BITS-1:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[sltm_pkg::TLEN_W-1:0] = len;
    cfg_valid <= 1'b1;
    cfg_index <= sltm_pkg::REG_TEMPLATE_TEXT;
    cfg_data  <= text;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tmpl_text = text;
    cfg_index <= sltm_pkg::REG_TEMPLATE_LENGTH;
    cfg_data  <= len_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tmpl_len = len;
    cfg_valid <= 1'b0;
  endtask

  task automatic note_mismatch(input string what, input sltm_pkg::line_result_t got,
                               input sltm_pkg::line_result_t want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display({"%0t: %s: got len=%0d ovf=%0b sw=%0b eq=%0b num=%0d, ",
                "expected len=%0d ovf=%0b sw=%0b eq=%0b num=%0d"},
               $realtime, what, got.line_length, got.overflowed, got.starts_with_template,
               got.equals_template, got.trailing_number, want.line_length, want.overflowed,
               want.starts_with_template, want.equals_template, want.trailing_number);
  endtask

  // Check each result transfer against the oldest prediction, then pick the next ready
  always @(posedge clk) begin : result_check
    sltm_pkg::line_result_t got;
    sltm_pkg::line_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = sltm_pkg::line_result_t'(out_tdata[$bits(sltm_pkg::line_result_t)-1:0]);
      if (expected_lines.size() == 0) begin
        note_mismatch("result with nothing expected", got, '0);
      end else begin
        want = expected_lines.pop_front();
        if (got.line_length !== want.line_length || got.overflowed !== want.overflowed ||
            got.starts_with_template !== want.starts_with_template ||
            got.equals_template !== want.equals_template ||
            got.trailing_number !== want.trailing_number)
          note_mismatch("line result differs", got, want);
      end
    end
    out_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 30);
  end

  // Template length zero right after reset: every stored character is a digit candidate
  task automatic test_reset_state();
    send_line("", sltm_pkg::CHAR_CR);
    send_line("7", sltm_pkg::CHAR_LF);
    send_line("1x", sltm_pkg::CHAR_CR);
  endtask

  // Exact match, numbers at both ends, too many digits, non-digit, short line, mismatch
  task automatic test_template_match();
    drain_results();
    load_template(pack_text("OK"), 4'd2);
    send_line("OK", sltm_pkg::CHAR_CR);
    send_line("OK0", sltm_pkg::CHAR_LF);
    send_line("OK999", sltm_pkg::CHAR_CR);
    send_line("OK1000", sltm_pkg::CHAR_CR);
    send_line("OK1a", sltm_pkg::CHAR_LF);
    send_line("O", sltm_pkg::CHAR_CR);
    send_line("OX12", sltm_pkg::CHAR_CR);
  endtask

  // Bytes 0, 255 and 128 after the template count as non-digits
  task automatic test_byte_extremes();
    send_byte("O");
    send_byte("K");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(sltm_pkg::CHAR_LF);
  endtask

  // Length above eight behaves as eight
  task automatic test_length_clamp();
    drain_results();
    load_template(pack_text("ABCDEFGH"), 4'd15);
    send_line("ABCDEFGH5", sltm_pkg::CHAR_CR);
  endtask

  // Line longer than the buffer: extra bytes only set the overflow flag
  task automatic test_buffer_overflow();
    drain_results();
    load_template('0, 4'd0);
    for (int i = 0; i < BUF_DEPTH + 2; i++)
      send_byte("9");
    send_byte(sltm_pkg::CHAR_CR);
  endtask

  // Change the template between characters of one line
  task automatic test_midline_write();
    send_byte("1");
    send_byte("2");
    drain_results();
    load_template(pack_text("1"), 4'd1);
    send_line("3", sltm_pkg::CHAR_CR);
  endtask

  // Mostly template + digits lines, some corrupted, some noise, some past the buffer
  task automatic send_random_line();
    int unsigned kind;
    int unsigned tl;
    int unsigned n;
    int unsigned bad;
    logic [7:0]  term;
    tl   = active_tmpl_len();
    term = $urandom_range(0, 1) ? sltm_pkg::CHAR_CR : sltm_pkg::CHAR_LF;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      bad = ($urandom_range(0, 99) < 15 && tl != 0) ? $urandom_range(0, tl - 1) : tl;
      for (int i = 0; i < tl; i++)
        send_byte((i == bad) ? ~tmpl_text[8*i +: 8] : tmpl_text[8*i +: 8]);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_byte(8'($urandom_range(58, 255)));
        else
          send_byte(sltm_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
    end else if (kind < 82) begin
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom_range(0, 255)));
    end else if (kind < 88) begin
      n = $urandom_range(BUF_DEPTH - 4, BUF_DEPTH + 6);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom_range(14, 255)));
    end else begin
      n = $urandom_range(0, tl);
      for (int i = 0; i < n; i++)
        send_byte(tmpl_text[8*i +: 8]);
    end
    send_byte(term);
  endtask

  // Random phases, each under its own template setting
  task automatic test_random_lines();
    logic [sltm_pkg::TMPL_BITS-1:0] text;
    logic [sltm_pkg::TLEN_W-1:0]    len;
    int unsigned                    budget;
    for (int p = 0; p < 8; p++) begin
      drain_results();
      for (int i = 0; i < sltm_pkg::TMPL_MAX; i++)
        text[8*i +: 8] = (p % 2 == 0) ? 8'($urandom_range(33, 126)) :
                                        8'($urandom_range(0, 255));
      len = sltm_pkg::TLEN_W'($urandom_range(0, 15));
      case (p)
        0: begin
          text = '0;
          len  = '0;
        end
        1: begin
          text = '1;
          len  = sltm_pkg::TLEN_W'(sltm_pkg::TMPL_MAX);
        end
        2: len = '1;
        default: ;
      endcase
      load_template(text, len);
      steady = (p == 3);
      budget = bytes_sent + 120;
      while (bytes_sent < budget)
        send_random_line();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= sltm_pkg::REG_TEMPLATE_TEXT;
    cfg_data  <= '0;
    tmpl_text      = '0;
    tmpl_len       = '0;
    mismatch_count = 0;
    bytes_sent     = 0;
    steady         = 1'b0;
    clear_line_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_template_match();
    test_byte_extremes();
    test_length_clamp();
    test_buffer_overflow();
    test_midline_write();
    test_random_lines();

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_lines.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- serial_line_template_matcher_unit.f -----
sv/sltm_pkg.sv
sv/sltm_cfg_regs.sv
sv/sltm_line_scan.sv
sv/serial_line_template_matcher_unit.sv
tb/sv/serial_line_template_matcher_unit_tb.sv
